// ===== src/irt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval reservation table package
// Sizes, operation and status codes, and the structs shared by the table
// controller, its storage cells and the port checker.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_IDX_W  = 6;
    localparam int TOTAL_W     = 6;
    localparam int CMP_W       = (CNT_W > SLOT_IDX_W) ? CNT_W : SLOT_IDX_W;

    localparam int OP_W   = 2;
    localparam int STAT_W = 3;
    localparam int ID_W   = 16;
    localparam int CH_W   = 8;
    localparam int MIN_W  = 11;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERLAP   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_INDEX = 3'd4
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CH_W-1:0]  channel;
        logic [MIN_W-1:0] start;
        logic [MIN_W-1:0] length;
    } entry_t;

    // Broadcast to every cell
    typedef struct packed {
        op_t    op;
        entry_t ent;
    } req_t;

    // Per-cell control from the table controller
    typedef struct packed {
        logic occupied;
        logic write;
        logic remove_go;
        logic read_sel;
    } cell_cmd_t;

endpackage

// ===== src/interval_reservation_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval reservation table
// Compacted table of time reservations held in a row of cells, with insert
// (overlap-checked), remove by id with shift-down, and read by index.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (valid/ready) and carry an operation:
//   insert, remove by id, read by index, or the unused code, which is ignored.
//   Every request yields exactly one response on the m_ channel with a status,
//   the entry read (zero unless a read succeeds) and the entry count after it.
//   The response is registered at the edge that accepts the request. Throughput
//   is one request per cycle while responses are taken; all cells compare their
//   entries in parallel and the remove shift completes in the same edge.
//   The output register frees up when m_ready takes the response, so a new
//   request is accepted while the old one is taken; when the receiver stalls,
//   s_ready drops and the response holds.
//   Reset empties the table (count cleared) and drops m_valid; entry storage
//   is not cleared, as only positions below the count are ever read.
// ----------------------------------------------------------------------------
module interval_reservation_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_res_id,
    input  logic [7:0]  s_channel_no,
    input  logic [10:0] s_start_minute,
    input  logic [10:0] s_length_minutes,
    input  logic [5:0]  s_slot_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_out_id,
    output logic [7:0]  m_out_channel,
    output logic [10:0] m_out_start,
    output logic [10:0] m_out_length,
    output logic [5:0]  m_entry_total
);
    import irt_pkg::*;

    req_t                   req;
    cell_cmd_t              cmd     [TABLE_DEPTH];
    entry_t                 entries [TABLE_DEPTH];
    entry_t                 nbr     [TABLE_DEPTH];
    entry_t                 rd      [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] clash_vec;
    logic [TABLE_DEPTH:0]   match_chain;

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    status_t          status_reg;
    status_t          status_next;
    entry_t           data_reg;
    entry_t           data_next;
    logic [TOTAL_W-1:0] total_reg;

    logic             fire;
    logic             full;
    logic             overlap_any;
    logic             found;
    logic             idx_ok;
    logic             insert_go;
    logic [CMP_W-1:0] fill_ext;
    logic [CMP_W-1:0] fill_next_ext;
    logic [CMP_W-1:0] idx_ext;
    entry_t           read_or;

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    assign req.op         = op_t'(s_operation);
    assign req.ent.id     = s_res_id;
    assign req.ent.channel = s_channel_no;
    assign req.ent.start  = s_start_minute;
    assign req.ent.length = s_length_minutes;

    assign full        = (fill_reg == CNT_W'(TABLE_DEPTH));
    assign overlap_any = |clash_vec;
    assign found       = match_chain[0];
    assign fill_ext    = CMP_W'(fill_reg);
    assign idx_ext     = CMP_W'(s_slot_index);
    assign idx_ok      = idx_ext < fill_ext;
    assign insert_go   = fire && (req.op == OP_INSERT) && !full && !overlap_any;

    assign match_chain[TABLE_DEPTH] = 1'b0;

    genvar k;
    generate
        for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
            assign cmd[k].occupied  = CNT_W'(k) < fill_reg;
            assign cmd[k].write     = insert_go && (CNT_W'(k) == fill_reg);
            assign cmd[k].remove_go = fire && (req.op == OP_REMOVE) && found;
            assign cmd[k].read_sel  = idx_ext == CMP_W'(k);

            if (k == TABLE_DEPTH - 1) begin : g_top
                assign nbr[k] = '0;
            end else begin : g_mid
                assign nbr[k] = entries[k+1];
            end

            irt_cell u_cell (
                .aclk            (aclk),
                .req             (req),
                .cmd             (cmd[k]),
                .nbr_entry       (nbr[k]),
                .match_above_in  (match_chain[k+1]),
                .match_above_out (match_chain[k]),
                .clash           (clash_vec[k]),
                .entry_out       (entries[k]),
                .read_data       (rd[k])
            );
        end
    endgenerate

    always_comb begin
        read_or = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            read_or = read_or | rd[i];
        end
    end

    always_comb begin
        status_next = ST_OK;
        data_next   = '0;
        fill_next   = fill_reg;
        case (req.op)
            OP_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else if (overlap_any) begin
                    status_next = ST_OVERLAP;
                end else begin
                    fill_next = fill_reg + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (found) begin
                    fill_next = fill_reg - CNT_W'(1);
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_READ: begin
                if (idx_ok) begin
                    data_next = read_or;
                end else begin
                    status_next = ST_BAD_INDEX;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    assign fill_next_ext = CMP_W'(fill_next);
    assign m_valid_next  = fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (fire) begin
                fill_reg <= fill_next;
            end
        end
    end

    // Response payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (fire) begin
            status_reg <= status_next;
            data_reg   <= data_next;
            total_reg  <= fill_next_ext[TOTAL_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_out_id      = data_reg.id;
    assign m_out_channel = data_reg.channel;
    assign m_out_start   = data_reg.start;
    assign m_out_length  = data_reg.length;
    assign m_entry_total = total_reg;

endmodule

// ===== src/irt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reservation cell
// Holds one table entry, checks it against the broadcast request for id match
// and time overlap, and takes its upper neighbor's entry on a remove shift.
// ----------------------------------------------------------------------------
module irt_cell (
    input  logic               aclk,
    input  irt_pkg::req_t      req,
    input  irt_pkg::cell_cmd_t cmd,
    input  irt_pkg::entry_t    nbr_entry,
    input  logic               match_above_in,
    output logic               match_above_out,
    output logic               clash,
    output irt_pkg::entry_t    entry_out,
    output irt_pkg::entry_t    read_data
);
    import irt_pkg::*;

    entry_t           entry_reg;
    entry_t           entry_next;
    logic             id_hit;
    logic [MIN_W:0]   a_end;
    logic [MIN_W:0]   b_end;
    logic [MIN_W:0]   lo_end;
    logic [MIN_W-1:0] hi_start;

    assign id_hit          = cmd.occupied && (entry_reg.id == req.ent.id);
    assign match_above_out = match_above_in | id_hit;

    // End times at full width, no wrap
    assign a_end    = {1'b0, req.ent.start} + {1'b0, req.ent.length};
    assign b_end    = {1'b0, entry_reg.start} + {1'b0, entry_reg.length};
    assign lo_end   = (a_end < b_end) ? a_end : b_end;
    assign hi_start = (req.ent.start > entry_reg.start) ? req.ent.start : entry_reg.start;
    assign clash    = cmd.occupied && (entry_reg.channel == req.ent.channel)
                      && (lo_end > {1'b0, hi_start});

    // Shift down when no later entry matches: this cell is at or above the last match
    always_comb begin
        entry_next = entry_reg;
        if (cmd.write) begin
            entry_next = req.ent;
        end else if (cmd.remove_go && !match_above_in) begin
            entry_next = nbr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;
    assign read_data = cmd.read_sel ? entry_reg : '0;

endmodule

// ===== src/irt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interval reservation table port checker
// Watches the top-level ports for response sanity and output handshake rules.
// ----------------------------------------------------------------------------
module irt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [15:0] m_out_id,
    input logic [7:0]  m_out_channel,
    input logic [10:0] m_out_start,
    input logic [10:0] m_out_length,
    input logic [5:0]  m_entry_total
);
    import irt_pkg::*;

    // No response pending right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("response valid after reset");

    // A free output register must take a request
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request blocked with empty output");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_OVERLAP || m_status == ST_FULL
                     || m_status == ST_NOT_FOUND || m_status == ST_BAD_INDEX))
        else $error("status code out of range");

    // Only a successful read carries entry data
    a_error_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |->
            (m_out_id == '0 && m_out_channel == '0 && m_out_start == '0
             && m_out_length == '0))
        else $error("entry data on failed request");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
                                   && $stable(m_entry_total) && $stable(m_out_id)))
        else $error("stalled response changed");

endmodule

bind interval_reservation_table irt_checker u_irt_checker (.*);
